// ----- rtl/adpe_pkg.sv -----
// adpe_pkg: shared widths, codes, word types and opcode tables
// for the aarch64 data-processing encoder; no dependencies
package adpe_pkg;

  localparam int unsigned KIND_W  = 5;
  localparam int unsigned REG_W   = 5;
  localparam int unsigned IMM_W   = 16;
  localparam int unsigned SKIND_W = 2;
  localparam int unsigned SAMT_W  = 6;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ERR_W   = 3;

  localparam logic [REG_W-1:0] ZERO_REG  = 5'd31;
  localparam logic [IMM_W-1:0] IMM12_MAX = 16'h0fff;
  localparam logic [9:0]       MUL_OPC   = 10'h0d8;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD  = 5'd0,
    KIND_ADDS = 5'd1,
    KIND_SUB  = 5'd2,
    KIND_SUBS = 5'd3,
    KIND_AND  = 5'd4,
    KIND_ANDS = 5'd5,
    KIND_BIC  = 5'd6,
    KIND_BICS = 5'd7,
    KIND_EOR  = 5'd8,
    KIND_EON  = 5'd9,
    KIND_ORR  = 5'd10,
    KIND_ORN  = 5'd11,
    KIND_MOVN = 5'd12,
    KIND_MOVZ = 5'd13,
    KIND_MOVK = 5'd14,
    KIND_MADD = 5'd15,
    KIND_MSUB = 5'd16,
    KIND_CMP  = 5'd17,
    KIND_CMN  = 5'd18,
    KIND_NEG  = 5'd19,
    KIND_NEGS = 5'd20,
    KIND_TST  = 5'd21,
    KIND_MVN  = 5'd22,
    KIND_MOV  = 5'd23,
    KIND_MUL  = 5'd24,
    KIND_MNEG = 5'd25
  } kind_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 3'd0,
    ERR_ROR   = 3'd1,
    ERR_IMM   = 3'd2,
    ERR_SHIFT = 3'd3,
    ERR_FORM  = 3'd4
  } err_e;

  localparam logic [SKIND_W-1:0] SHIFT_LSL = 2'd0;
  localparam logic [SKIND_W-1:0] SHIFT_ROR = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               wide;
    logic [REG_W-1:0]   first_reg;
    logic [REG_W-1:0]   second_reg;
    logic [REG_W-1:0]   third_reg;
    logic [REG_W-1:0]   fourth_reg;
    logic               last_is_register;
    logic [IMM_W-1:0]   immediate;
    logic               has_shift;
    logic [SKIND_W-1:0] shift_kind;
    logic [SAMT_W-1:0]  shift_amount;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] machine_word;
    err_e              error;
  } result_t;

  // register-form opcode, placed at bit 21
  function automatic logic [9:0] reg_opc(input logic [KIND_W-1:0] base);
    logic [9:0] opc;
    case (base)
      KIND_ADD:  opc = 10'h058;
      KIND_ADDS: opc = 10'h158;
      KIND_SUB:  opc = 10'h258;
      KIND_SUBS: opc = 10'h358;
      KIND_AND:  opc = 10'h050;
      KIND_ANDS: opc = 10'h350;
      KIND_BIC:  opc = 10'h051;
      KIND_BICS: opc = 10'h351;
      KIND_EOR:  opc = 10'h250;
      KIND_EON:  opc = 10'h251;
      KIND_ORR:  opc = 10'h150;
      KIND_ORN:  opc = 10'h151;
      KIND_MADD: opc = MUL_OPC;
      KIND_MSUB: opc = MUL_OPC;
      default:   opc = 10'h000;
    endcase
    return opc;
  endfunction

  // immediate-form opcode, placed at bit 23
  function automatic logic [7:0] imm_opc(input logic [KIND_W-1:0] base);
    logic [7:0] opc;
    case (base)
      KIND_ADD:  opc = 8'h22;
      KIND_ADDS: opc = 8'h62;
      KIND_SUB:  opc = 8'ha2;
      KIND_SUBS: opc = 8'he2;
      KIND_MOVN: opc = 8'h25;
      KIND_MOVZ: opc = 8'ha5;
      KIND_MOVK: opc = 8'he5;
      default:   opc = 8'h00;
    endcase
    return opc;
  endfunction

endpackage

// ----- rtl/adpe_in_if.sv -----
// adpe_in_if: valid/ready channel carrying one parsed instruction word
// depends on adpe_pkg
interface adpe_in_if;
  import adpe_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic               wide;
  logic [REG_W-1:0]   first_reg;
  logic [REG_W-1:0]   second_reg;
  logic [REG_W-1:0]   third_reg;
  logic [REG_W-1:0]   fourth_reg;
  logic               last_is_register;
  logic [IMM_W-1:0]   immediate;
  logic               has_shift;
  logic [SKIND_W-1:0] shift_kind;
  logic [SAMT_W-1:0]  shift_amount;

  modport source (
    output valid, kind, wide, first_reg, second_reg, third_reg, fourth_reg,
           last_is_register, immediate, has_shift, shift_kind, shift_amount,
    input  ready
  );

  modport sink (
    input  valid, kind, wide, first_reg, second_reg, third_reg, fourth_reg,
           last_is_register, immediate, has_shift, shift_kind, shift_amount,
    output ready
  );
endinterface

// ----- rtl/adpe_out_if.sv -----
// adpe_out_if: valid/ready channel carrying one encoded machine word
// depends on adpe_pkg
interface adpe_out_if;
  import adpe_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] machine_word;
  logic [ERR_W-1:0]  error;

  modport source (
    output valid, machine_word, error,
    input  ready
  );

  modport sink (
    input  valid, machine_word, error,
    output ready
  );
endinterface

// ----- rtl/adpe_core.sv -----
// adpe_core: alias expansion, form selection and field packing for one word
// purely combinational; depends on adpe_pkg
module adpe_core (
  input  adpe_pkg::item_t   item_i,
  output adpe_pkg::result_t res_o
);
  import adpe_pkg::*;

  always_comb begin
    logic [KIND_W-1:0] base;
    logic [REG_W-1:0]  rd, rn, rm, ra;
    logic              imm_ok, shift_ok, unknown;
    logic [1:0]        hw;
    logic [WORD_W-1:0] word;
    err_e              err;

    base     = item_i.kind;
    rd       = item_i.first_reg;
    rn       = item_i.second_reg;
    rm       = item_i.third_reg;
    ra       = item_i.fourth_reg;
    imm_ok   = 1'b1;
    shift_ok = 1'b1;
    unknown  = 1'b0;
    hw       = 2'd0;
    word     = '0;
    err      = ERR_NONE;

    // alias expansion
    case (item_i.kind)
      KIND_CMP, KIND_CMN: begin
        base = (item_i.kind == KIND_CMN) ? KIND_ADDS : KIND_SUBS;
        rd   = ZERO_REG;
        rn   = item_i.first_reg;
        rm   = item_i.second_reg;
      end
      KIND_NEG, KIND_NEGS: begin
        base   = (item_i.kind == KIND_NEGS) ? KIND_SUBS : KIND_SUB;
        rn     = ZERO_REG;
        rm     = item_i.second_reg;
        imm_ok = 1'b0;
      end
      KIND_TST: begin
        base   = KIND_ANDS;
        rd     = ZERO_REG;
        rn     = item_i.first_reg;
        rm     = item_i.second_reg;
        imm_ok = 1'b0;
      end
      KIND_MVN: begin
        base   = KIND_ORN;
        rn     = ZERO_REG;
        rm     = item_i.second_reg;
        imm_ok = 1'b0;
      end
      KIND_MOV: begin
        base     = KIND_ORR;
        rn       = ZERO_REG;
        rm       = item_i.second_reg;
        imm_ok   = 1'b0;
        shift_ok = 1'b0;
      end
      KIND_MUL, KIND_MNEG: begin
        base = (item_i.kind == KIND_MNEG) ? KIND_MSUB : KIND_MADD;
        ra   = ZERO_REG;
      end
      default: begin
        unknown = (item_i.kind > KIND_MSUB);
      end
    endcase

    if (base >= KIND_MADD) begin
      imm_ok   = 1'b0;
      shift_ok = 1'b0;
    end
    if (base >= KIND_AND && base <= KIND_ORN) begin
      imm_ok = 1'b0;
    end

    if (unknown) begin
      err = ERR_FORM;
    end else if (!item_i.last_is_register && !imm_ok) begin
      err = ERR_FORM;
    end else if (item_i.has_shift && !shift_ok) begin
      err = ERR_FORM;
    end else if (base >= KIND_MOVN && base <= KIND_MOVK) begin
      hw = item_i.has_shift ? item_i.shift_amount[5:4] : 2'd0;
      if (item_i.last_is_register) begin
        err = ERR_FORM;
      end else if (item_i.has_shift && (item_i.shift_kind != SHIFT_LSL ||
                   item_i.shift_amount[3:0] != 4'd0)) begin
        err = ERR_SHIFT;
      end else if (!item_i.wide && hw[1]) begin
        err = ERR_SHIFT;
      end
      word = (WORD_W'(imm_opc(base)) << 23) | (WORD_W'(hw) << 21) |
             (WORD_W'(item_i.immediate) << 5) | WORD_W'(rd);
    end else if (base >= KIND_MADD) begin
      word = (WORD_W'(MUL_OPC) << 21) | (WORD_W'(rm) << 16) |
             (WORD_W'(base == KIND_MSUB) << 15) | (WORD_W'(ra) << 10) |
             (WORD_W'(rn) << 5) | WORD_W'(rd);
    end else if (item_i.last_is_register) begin
      word = (WORD_W'(reg_opc(base)) << 21) | (WORD_W'(rm) << 16) |
             (WORD_W'(rn) << 5) | WORD_W'(rd);
      if (item_i.has_shift) begin
        if (base <= KIND_SUBS && item_i.shift_kind == SHIFT_ROR) begin
          err = ERR_ROR;
        end else if (!item_i.wide && item_i.shift_amount[5]) begin
          err = ERR_SHIFT;
        end
        word = word | (WORD_W'(item_i.shift_kind) << 22) |
               (WORD_W'(item_i.shift_amount) << 10);
      end
    end else begin
      if (item_i.immediate > IMM12_MAX) begin
        err = ERR_IMM;
      end else if (item_i.has_shift && item_i.shift_kind != SHIFT_LSL) begin
        err = ERR_SHIFT;
      end else if (item_i.has_shift && item_i.shift_amount != 6'd12 &&
                   item_i.shift_amount != 6'd0) begin
        err = ERR_SHIFT;
      end
      word = (WORD_W'(imm_opc(base)) << 23) | (WORD_W'(item_i.immediate) << 10) |
             (WORD_W'(rn) << 5) | WORD_W'(rd);
      if (item_i.has_shift && item_i.shift_amount == 6'd12) begin
        word = word | (WORD_W'(1'b1) << 22);
      end
    end

    word = word | (WORD_W'(item_i.wide) << 31);

    res_o.machine_word = (err == ERR_NONE) ? word : '0;
    res_o.error        = err;
  end

endmodule

// ----- rtl/arm64_data_processing_encoder.sv -----
// arm64_data_processing_encoder: aarch64 data-processing instruction encoder
// an accepted input word passes the input register, then the result register
// throughput: one word per cycle while the result side does not hold off ready
// input is ready when the input register is empty, or the result register is empty or taken this cycle
// reset (rst_ni low, async) clears both valid flags; payload is not reset
// depends on adpe_pkg, adpe_in_if, adpe_out_if, adpe_core
module arm64_data_processing_encoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  adpe_in_if.sink           in_i,
  adpe_out_if.source        out_o
);
  import adpe_pkg::*;

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  result_t res;
  logic    out_adv;
  logic    in_adv;

  // result register frees when empty or taken
  assign out_adv   = !out_valid_q || out_o.ready;
  assign in_adv    = !in_valid_q || out_adv;
  assign in_i.ready = in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_q <= in_i.valid;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_i.valid) begin
      in_item_q.kind             <= in_i.kind;
      in_item_q.wide             <= in_i.wide;
      in_item_q.first_reg        <= in_i.first_reg;
      in_item_q.second_reg       <= in_i.second_reg;
      in_item_q.third_reg        <= in_i.third_reg;
      in_item_q.fourth_reg       <= in_i.fourth_reg;
      in_item_q.last_is_register <= in_i.last_is_register;
      in_item_q.immediate        <= in_i.immediate;
      in_item_q.has_shift        <= in_i.has_shift;
      in_item_q.shift_kind       <= in_i.shift_kind;
      in_item_q.shift_amount     <= in_i.shift_amount;
    end
    if (out_adv && in_valid_q) begin
      out_res_q <= res;
    end
  end

  adpe_core u_core (
    .item_i (in_item_q),
    .res_o  (res)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.machine_word = out_res_q.machine_word;
  assign out_o.error        = out_res_q.error;

endmodule

// ----- tb/arm64_data_processing_encoder_tb.sv -----
// arm64_data_processing_encoder_tb: checks the instruction encoder against its own encoding
// predictor through the valid/ready words, using random idling and back-pressure
// depends on adpe_pkg, adpe_in_if, adpe_out_if and arm64_data_processing_encoder
module arm64_data_processing_encoder_tb;
  import adpe_pkg::*;

  localparam logic [SKIND_W-1:0] SHIFT_LSR = 2'd1;
  localparam logic [SKIND_W-1:0] SHIFT_ASR = 2'd2;
  localparam logic [KIND_W-1:0]  KIND_BAD  = 5'd31;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT = 200000;

  class encoder_scoreboard;
    result_t     expected_q[$];
    item_t       source_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned clean;
    int unsigned rejected;

    function logic [7:0] imm_opcode(logic [KIND_W-1:0] base);
      case (base)
        KIND_ADD:  return 8'h22;
        KIND_ADDS: return 8'h62;
        KIND_SUB:  return 8'ha2;
        KIND_SUBS: return 8'he2;
        KIND_MOVN: return 8'h25;
        KIND_MOVZ: return 8'ha5;
        KIND_MOVK: return 8'he5;
        default:   return 8'h00;
      endcase
    endfunction

    function logic [9:0] reg_opcode(logic [KIND_W-1:0] base);
      case (base)
        KIND_ADD:  return 10'h058;
        KIND_ADDS: return 10'h158;
        KIND_SUB:  return 10'h258;
        KIND_SUBS: return 10'h358;
        KIND_AND:  return 10'h050;
        KIND_ANDS: return 10'h350;
        KIND_BIC:  return 10'h051;
        KIND_BICS: return 10'h351;
        KIND_EOR:  return 10'h250;
        KIND_EON:  return 10'h251;
        KIND_ORR:  return 10'h150;
        KIND_ORN:  return 10'h151;
        default:   return 10'h000;
      endcase
    endfunction

    function result_t encode(item_t it);
      logic [KIND_W-1:0] base;
      logic [REG_W-1:0]  rd;
      logic [REG_W-1:0]  rn;
      logic [REG_W-1:0]  rm;
      logic [REG_W-1:0]  ra;
      logic [1:0]        hw;
      logic              imm_ok;
      logic              shift_ok;
      logic [WORD_W-1:0] word;
      err_e              err;
      result_t           res;
      rd = it.first_reg;
      rn = it.second_reg;
      rm = it.third_reg;
      ra = it.fourth_reg;
      base = it.kind;
      imm_ok = 1'b1;
      shift_ok = 1'b1;
      word = '0;
      hw = '0;
      err = ERR_NONE;
      // alias expansion
      case (it.kind)
        KIND_CMP, KIND_CMN: begin
          base = (it.kind == KIND_CMN) ? KIND_ADDS : KIND_SUBS;
          rd = ZERO_REG;
          rn = it.first_reg;
          rm = it.second_reg;
        end
        KIND_NEG, KIND_NEGS: begin
          base = (it.kind == KIND_NEGS) ? KIND_SUBS : KIND_SUB;
          rn = ZERO_REG;
          rm = it.second_reg;
          imm_ok = 1'b0;
        end
        KIND_TST: begin
          base = KIND_ANDS;
          rd = ZERO_REG;
          rn = it.first_reg;
          rm = it.second_reg;
          imm_ok = 1'b0;
        end
        KIND_MVN: begin
          base = KIND_ORN;
          rn = ZERO_REG;
          rm = it.second_reg;
          imm_ok = 1'b0;
        end
        KIND_MOV: begin
          base = KIND_ORR;
          rn = ZERO_REG;
          rm = it.second_reg;
          imm_ok = 1'b0;
          shift_ok = 1'b0;
        end
        KIND_MUL, KIND_MNEG: begin
          base = (it.kind == KIND_MNEG) ? KIND_MSUB : KIND_MADD;
          ra = ZERO_REG;
        end
        default: begin
          if (it.kind > KIND_MSUB) err = ERR_FORM;
        end
      endcase
      if (base >= KIND_MADD) begin
        imm_ok = 1'b0;
        shift_ok = 1'b0;
      end
      if (base >= KIND_AND && base <= KIND_ORN) imm_ok = 1'b0;
      if (err == ERR_NONE && !it.last_is_register && !imm_ok) err = ERR_FORM;
      if (err == ERR_NONE && it.has_shift && !shift_ok) err = ERR_FORM;
      if (err == ERR_NONE) begin
        if (base >= KIND_MOVN && base <= KIND_MOVK) begin
          if (it.last_is_register) begin
            err = ERR_FORM;
          end else if (it.has_shift && (it.shift_kind != SHIFT_LSL ||
                                        it.shift_amount[3:0] != 4'd0)) begin
            err = ERR_SHIFT;
          end else begin
            if (it.has_shift) hw = it.shift_amount[5:4];
            if (!it.wide && hw > 2'd1) err = ERR_SHIFT;
            word = {1'b0, imm_opcode(base), hw, it.immediate, rd};
          end
        end else if (base >= KIND_MADD) begin
          word = {3'b000, 8'hd8, rm, base == KIND_MSUB, ra, rn, rd};
        end else if (it.last_is_register) begin
          word = {1'b0, reg_opcode(base), rm, 6'd0, rn, rd};
          if (it.has_shift) begin
            if (base <= KIND_SUBS && it.shift_kind == SHIFT_ROR) begin
              err = ERR_ROR;
            end else if (!it.wide && it.shift_amount[5]) begin
              err = ERR_SHIFT;
            end else begin
              word[23:22] = word[23:22] | it.shift_kind;
              word[15:10] = it.shift_amount;
            end
          end
        end else begin
          if (it.immediate > IMM12_MAX) begin
            err = ERR_IMM;
          end else if (it.has_shift && (it.shift_kind != SHIFT_LSL ||
                       (it.shift_amount != 6'd0 && it.shift_amount != 6'd12))) begin
            err = ERR_SHIFT;
          end else begin
            word = {1'b0, imm_opcode(base), it.has_shift && it.shift_amount == 6'd12,
                    it.immediate[11:0], rn, rd};
          end
        end
      end
      word[31] = it.wide;
      res.machine_word = (err == ERR_NONE) ? word : '0;
      res.error = err;
      return res;
    endfunction

    function void note_input(item_t it);
      result_t res;
      res = encode(it);
      expected_q.push_back(res);
      source_q.push_back(it);
      if (res.error == ERR_NONE) clean++;
      else rejected++;
    endfunction

    function void check_result(logic [WORD_W-1:0] word, logic [ERR_W-1:0] err);
      result_t want;
      item_t   it;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h error %0d", word, err);
        return;
      end
      want = expected_q.pop_front();
      it = source_q.pop_front();
      if (word !== want.machine_word || err !== want.error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on item %h: expected word %h error %0d, got word %h error %0d",
                   it, want.machine_word, want.error, word, err);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic gaps_on;
  logic stall_on;
  logic hold_req;
  int unsigned cycle_count = 0;
  int unsigned hold_count;
  encoder_scoreboard sb = new;
  item_t directed_q[$];

  adpe_in_if  in_ch();
  adpe_out_if out_ch();

  arm64_data_processing_encoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.machine_word, out_ch.error);
  end

  // result side: random stalls plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic item_t mk(logic [KIND_W-1:0] k, logic w, logic [REG_W-1:0] a,
                               logic [REG_W-1:0] b, logic [REG_W-1:0] c,
                               logic [REG_W-1:0] d, logic isreg, logic [IMM_W-1:0] imm,
                               logic sh, logic [SKIND_W-1:0] sk, logic [SAMT_W-1:0] sa);
    item_t it;
    it = {k, w, a, b, c, d, isreg, imm, sh, sk, sa};
    return it;
  endfunction

  // mostly well-formed instructions with random operands, the rest raw noise
  function automatic item_t rand_item();
    item_t it;
    it.kind = ($urandom_range(0, 24) == 0) ? 5'($urandom_range(KIND_MNEG + 1, KIND_BAD))
                                          : 5'($urandom_range(0, KIND_MNEG));
    it.wide = 1'($urandom_range(0, 1));
    it.first_reg = 5'($urandom_range(0, 31));
    it.second_reg = 5'($urandom_range(0, 31));
    it.third_reg = 5'($urandom_range(0, 31));
    it.fourth_reg = 5'($urandom_range(0, 31));
    it.last_is_register = 1'($urandom_range(0, 1));
    it.immediate = 16'($urandom_range(0, 65535));
    it.has_shift = 1'($urandom_range(0, 1));
    it.shift_kind = 2'($urandom_range(0, 3));
    it.shift_amount = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 9) != 0) begin
      case (it.kind)
        KIND_ADD, KIND_ADDS, KIND_SUB, KIND_SUBS, KIND_CMP, KIND_CMN: begin
          if (!it.last_is_register) begin
            it.immediate = 16'($urandom_range(0, IMM12_MAX));
            it.shift_kind = SHIFT_LSL;
            it.shift_amount = ($urandom_range(0, 1) != 0) ? 6'd12 : 6'd0;
          end else begin
            it.shift_kind = 2'($urandom_range(0, 2));
            if (!it.wide) it.shift_amount[5] = 1'b0;
          end
        end
        KIND_MOVN, KIND_MOVZ, KIND_MOVK: begin
          it.last_is_register = 1'b0;
          it.shift_kind = SHIFT_LSL;
          it.shift_amount = {2'($urandom_range(0, it.wide ? 3 : 1)), 4'd0};
        end
        KIND_MOV, KIND_MADD, KIND_MSUB, KIND_MUL, KIND_MNEG: begin
          it.last_is_register = 1'b1;
          it.has_shift = 1'b0;
        end
        default: begin
          it.last_is_register = 1'b1;
          if (!it.wide) it.shift_amount[5] = 1'b0;
        end
      endcase
    end
    return it;
  endfunction

  task automatic put_fields(item_t it);
    in_ch.kind             <= it.kind;
    in_ch.wide             <= it.wide;
    in_ch.first_reg        <= it.first_reg;
    in_ch.second_reg       <= it.second_reg;
    in_ch.third_reg        <= it.third_reg;
    in_ch.fourth_reg       <= it.fourth_reg;
    in_ch.last_is_register <= it.last_is_register;
    in_ch.immediate        <= it.immediate;
    in_ch.has_shift        <= it.has_shift;
    in_ch.shift_kind       <= it.shift_kind;
    in_ch.shift_amount     <= it.shift_amount;
  endtask

  task automatic send_item(item_t it);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    put_fields(it);
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    rst_n = 1'b0;
    gaps_on = 1'b0;
    stall_on = 1'b0;
    hold_req = 1'b0;
    in_ch.valid <= 1'b0;
    put_fields('0);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_q.push_back(mk(KIND_ADD,  1, 0, 1, 2, 3, 0, 16'h0fff, 1, SHIFT_LSL, 6'd12));
    directed_q.push_back(mk(KIND_ADDS, 0, 31, 31, 31, 31, 1, 16'h0000, 1, SHIFT_LSL, 6'd31));
    directed_q.push_back(mk(KIND_SUB,  1, 4, 5, 6, 7, 1, 16'h0000, 1, SHIFT_ROR, 6'd3));
    directed_q.push_back(mk(KIND_SUBS, 1, 8, 9, 10, 11, 0, 16'h1000, 1, SHIFT_LSL, 6'd0));
    directed_q.push_back(mk(KIND_ADD,  0, 2, 3, 0, 0, 0, 16'h0010, 1, SHIFT_LSL, 6'd6));
    directed_q.push_back(mk(KIND_AND,  1, 12, 13, 14, 15, 1, 16'hffff, 1, SHIFT_ROR, 6'd63));
    directed_q.push_back(mk(KIND_ANDS, 0, 1, 2, 3, 4, 0, 16'h0001, 0, SHIFT_LSL, 6'd0));
    directed_q.push_back(mk(KIND_BIC,  0, 5, 6, 7, 8, 1, 16'h0000, 1, SHIFT_LSR, 6'd32));
    directed_q.push_back(mk(KIND_BICS, 1, 9, 10, 11, 12, 1, 16'h0000, 1, SHIFT_ASR, 6'd0));
    directed_q.push_back(mk(KIND_EOR,  1, 31, 31, 31, 31, 1, 16'h0000, 0, SHIFT_LSL, 6'd0));
    directed_q.push_back(mk(KIND_EON,  0, 16, 17, 18, 19, 1, 16'h0000, 1, SHIFT_LSL, 6'd7));
    directed_q.push_back(mk(KIND_ORR,  0, 20, 21, 22, 23, 1, 16'h0000, 0, SHIFT_LSL, 6'd0));
    directed_q.push_back(mk(KIND_ORN,  1, 24, 25, 26, 27, 1, 16'h0000, 1, SHIFT_ROR, 6'd1));
    directed_q.push_back(mk(KIND_MOVN, 1, 0, 0, 0, 0, 0, 16'h0000, 0, SHIFT_LSL, 6'd0));
    directed_q.push_back(mk(KIND_MOVZ, 1, 31, 0, 0, 0, 0, 16'hffff, 1, SHIFT_LSL, 6'd48));
    directed_q.push_back(mk(KIND_MOVK, 0, 3, 0, 0, 0, 0, 16'h1234, 1, SHIFT_LSL, 6'd32));
    directed_q.push_back(mk(KIND_MOVN, 0, 3, 0, 0, 0, 0, 16'h8000, 1, SHIFT_LSL, 6'd8));
    directed_q.push_back(mk(KIND_MOVZ, 0, 3, 0, 0, 0, 1, 16'h0001, 0, SHIFT_LSL, 6'd0));
    directed_q.push_back(mk(KIND_MADD, 1, 1, 2, 3, 4, 1, 16'h0000, 0, SHIFT_LSL, 6'd0));
    directed_q.push_back(mk(KIND_MSUB, 0, 5, 6, 7, 8, 1, 16'h0000, 1, SHIFT_LSL, 6'd0));
    directed_q.push_back(mk(KIND_CMP,  1, 30, 29, 0, 0, 0, 16'h0abc, 1, SHIFT_LSL, 6'd12));
    directed_q.push_back(mk(KIND_CMN,  0, 2, 3, 0, 0, 0, 16'h0010, 1, SHIFT_LSR, 6'd0));
    directed_q.push_back(mk(KIND_NEG,  1, 7, 8, 0, 0, 1, 16'h0000, 1, SHIFT_ASR, 6'd17));
    directed_q.push_back(mk(KIND_NEGS, 0, 7, 8, 0, 0, 0, 16'h0005, 0, SHIFT_LSL, 6'd0));
    directed_q.push_back(mk(KIND_TST,  1, 9, 10, 0, 0, 1, 16'h0000, 1, SHIFT_ROR, 6'd40));
    directed_q.push_back(mk(KIND_MVN,  0, 11, 12, 0, 0, 1, 16'h0000, 1, SHIFT_LSL, 6'd31));
    directed_q.push_back(mk(KIND_MOV,  1, 13, 14, 0, 0, 1, 16'h0000, 0, SHIFT_LSL, 6'd0));
    directed_q.push_back(mk(KIND_MOV,  0, 13, 14, 0, 0, 1, 16'h0000, 1, SHIFT_LSL, 6'd0));
    directed_q.push_back(mk(KIND_MUL,  1, 15, 16, 17, 0, 1, 16'h0000, 0, SHIFT_LSL, 6'd0));
    directed_q.push_back(mk(KIND_MNEG, 0, 18, 19, 20, 0, 1, 16'h0000, 0, SHIFT_LSL, 6'd0));
    directed_q.push_back(mk(KIND_BAD,  1, 1, 1, 1, 1, 1, 16'hffff, 1, SHIFT_ROR, 6'd63));
    foreach (directed_q[i]) send_item(directed_q[i]);

    // long result hold-off while words keep coming, then a full pause on input
    gaps_on = 1'b1;
    stall_on = 1'b1;
    hold_req = 1'b1;
    repeat (500) send_item(rand_item());
    drain();

    repeat (500) send_item(rand_item());

    // closing stretch at full rate
    gaps_on = 1'b0;
    stall_on = 1'b0;
    repeat (220) send_item(rand_item());
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("encoded %0d instruction words over all mnemonics and unknown codes",
             sb.checked);
    $display("%0d packed cleanly, %0d flagged with an error code, %0d mismatches",
             sb.clean, sb.rejected, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
